// ===== src/nfs_pkg.sv =====
// Shared constants, types and command/status structs for the newline frame splitter.
package nfs_pkg;

    localparam int MAX_FRAME = 64;
    localparam int ADDR_W    = $clog2(MAX_FRAME);
    localparam int LEN_W     = $clog2(MAX_FRAME + 1);
    localparam int BYTE_W    = 8;
    localparam int COUNT_W   = 32;
    localparam int FIELD_W   = BYTE_W + COUNT_W + LEN_W;
    localparam int TDATA_W   = ((FIELD_W + 7) / 8) * 8;
    localparam int PAD_W     = TDATA_W - FIELD_W;

    localparam logic [BYTE_W-1:0] CH_CR = 8'h0D;
    localparam logic [BYTE_W-1:0] CH_LF = 8'h0A;

    localparam logic MODE_DATA  = 1'b0;
    localparam logic MODE_CLEAR = 1'b1;

    localparam logic KIND_FRAME  = 1'b0;
    localparam logic KIND_NOTICE = 1'b1;

    localparam logic [LEN_W-1:0]   LIMIT_RESET = LEN_W'(MAX_FRAME);
    localparam logic [COUNT_W-1:0] COUNT_MAX   = '1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_FETCH,
        ST_SEND
    } ctrl_state_t;

    typedef struct packed {
        logic accept;
        logic rd_en;
        logic emit;
    } ctrl_cmd_t;

    typedef struct packed {
        logic out_free;
        logic line_start;
        logic last_read;
    } dp_status_t;

endpackage

// ===== src/nfs_ctrl.sv =====
// Controller state machine: accepts words and sequences the read-out of a buffered line.
module nfs_ctrl (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  nfs_pkg::dp_status_t status,
    output nfs_pkg::ctrl_cmd_t  cmd
);

    nfs_pkg::ctrl_state_t state_reg;
    nfs_pkg::ctrl_state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= nfs_pkg::ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            nfs_pkg::ST_IDLE: begin
                if (s_tvalid && status.out_free && status.line_start) begin
                    state_next = nfs_pkg::ST_FETCH;
                end
            end
            nfs_pkg::ST_FETCH: begin
                state_next = nfs_pkg::ST_SEND;
            end
            nfs_pkg::ST_SEND: begin
                if (status.out_free && status.last_read) begin
                    state_next = nfs_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = nfs_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb begin
        s_tready   = 1'b0;
        cmd.accept = 1'b0;
        cmd.rd_en  = 1'b0;
        cmd.emit   = 1'b0;
        case (state_reg)
            nfs_pkg::ST_IDLE: begin
                s_tready   = status.out_free;
                cmd.accept = s_tvalid && status.out_free;
            end
            nfs_pkg::ST_FETCH: begin
                cmd.rd_en = 1'b1;
            end
            nfs_pkg::ST_SEND: begin
                cmd.emit  = status.out_free;
                cmd.rd_en = status.out_free && !status.last_read;
            end
            default: begin
                s_tready = 1'b0;
            end
        endcase
    end

endmodule

// ===== src/nfs_datapath.sv =====
// Datapath: line buffer, length, drop flag, reject counter, limit register and output register.
module nfs_datapath (
    input  logic                                   aclk,
    input  logic                                   aresetn,
    input  logic                                   cfg_wr_en,
    input  logic [nfs_pkg::LEN_W-1:0]              cfg_wr_data,
    input  logic [7:0]                             s_tdata,
    input  logic                                   s_tuser,
    output logic                                   m_tvalid,
    input  logic                                   m_tready,
    output logic [nfs_pkg::TDATA_W-1:0]            m_tdata,
    output logic                                   m_tuser,
    output logic                                   m_tlast,
    input  nfs_pkg::ctrl_cmd_t                     cmd,
    output nfs_pkg::dp_status_t                    status
);

    logic [nfs_pkg::BYTE_W-1:0] line_mem [nfs_pkg::MAX_FRAME];

    logic [nfs_pkg::LEN_W-1:0]   frame_limit_reg;
    logic [nfs_pkg::LEN_W-1:0]   line_length_reg, line_length_next;
    logic                        dropping_reg, dropping_next;
    logic [nfs_pkg::COUNT_W-1:0] reject_count_reg, reject_count_next;
    logic [nfs_pkg::BYTE_W-1:0]  last_byte_reg;
    logic [nfs_pkg::LEN_W-1:0]   emit_len_reg;
    logic [nfs_pkg::LEN_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [nfs_pkg::BYTE_W-1:0]  rd_data_reg;

    logic                        out_valid_reg, out_valid_next;
    logic                        out_kind_reg;
    logic                        out_last_reg;
    logic [nfs_pkg::BYTE_W-1:0]  out_byte_reg;
    logic [nfs_pkg::COUNT_W-1:0] out_total_reg;
    logic [nfs_pkg::LEN_W-1:0]   out_len_reg;

    logic [nfs_pkg::LEN_W-1:0]   limit_eff;
    logic [nfs_pkg::LEN_W-1:0]   emit_len;
    logic [nfs_pkg::COUNT_W-1:0] count_inc;
    logic                        is_lf;
    logic                        strip_cr;
    logic                        data_word;
    logic                        oversize;
    logic                        store_byte;
    logic                        notice_load;

    always_comb begin
        if (frame_limit_reg == '0) begin
            limit_eff = nfs_pkg::LEN_W'(1);
        end else if (frame_limit_reg > nfs_pkg::LIMIT_RESET) begin
            limit_eff = nfs_pkg::LIMIT_RESET;
        end else begin
            limit_eff = frame_limit_reg;
        end
    end

    assign is_lf     = (s_tdata == nfs_pkg::CH_LF);
    assign strip_cr  = (line_length_reg != '0) && (last_byte_reg == nfs_pkg::CH_CR);
    assign emit_len  = line_length_reg - nfs_pkg::LEN_W'(strip_cr);
    assign count_inc = (reject_count_reg == nfs_pkg::COUNT_MAX) ? reject_count_reg
                                                                : reject_count_reg + 1'b1;
    assign data_word = (s_tuser == nfs_pkg::MODE_DATA) && !dropping_reg;
    assign oversize  = data_word && !is_lf && (line_length_reg >= limit_eff);

    assign status.out_free   = !out_valid_reg || m_tready;
    assign status.line_start = data_word && is_lf && (emit_len != '0);
    assign status.last_read  = (rd_ptr_reg == emit_len_reg);

    assign store_byte  = cmd.accept && data_word && !is_lf && !oversize;
    assign notice_load = cmd.accept && oversize;

    always_comb begin
        line_length_next  = line_length_reg;
        dropping_next     = dropping_reg;
        reject_count_next = reject_count_reg;
        if (cmd.accept) begin
            if (s_tuser == nfs_pkg::MODE_CLEAR) begin
                line_length_next  = '0;
                dropping_next     = 1'b0;
                reject_count_next = '0;
            end else if (dropping_reg) begin
                if (is_lf) begin
                    dropping_next = 1'b0;
                end
            end else if (is_lf) begin
                line_length_next = '0;
            end else if (oversize) begin
                line_length_next  = '0;
                dropping_next     = 1'b1;
                reject_count_next = count_inc;
            end else begin
                line_length_next = line_length_reg + 1'b1;
            end
        end
    end

    always_comb begin
        rd_ptr_next = rd_ptr_reg;
        if (cmd.accept && status.line_start) begin
            rd_ptr_next = '0;
        end else if (cmd.rd_en) begin
            rd_ptr_next = rd_ptr_reg + 1'b1;
        end
    end

    always_comb begin
        out_valid_next = out_valid_reg;
        if (cmd.emit || notice_load) begin
            out_valid_next = 1'b1;
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            frame_limit_reg  <= nfs_pkg::LIMIT_RESET;
            line_length_reg  <= '0;
            dropping_reg     <= 1'b0;
            reject_count_reg <= '0;
            out_valid_reg    <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                frame_limit_reg <= cfg_wr_data;
            end
            line_length_reg  <= line_length_next;
            dropping_reg     <= dropping_next;
            reject_count_reg <= reject_count_next;
            out_valid_reg    <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        rd_ptr_reg <= rd_ptr_next;
        if (store_byte) begin
            line_mem[line_length_reg[nfs_pkg::ADDR_W-1:0]] <= s_tdata;
            last_byte_reg <= s_tdata;
        end
        if (cmd.accept && status.line_start) begin
            emit_len_reg <= emit_len;
        end
        if (cmd.rd_en) begin
            rd_data_reg <= line_mem[rd_ptr_reg[nfs_pkg::ADDR_W-1:0]];
        end
        if (notice_load) begin
            out_kind_reg  <= nfs_pkg::KIND_NOTICE;
            out_byte_reg  <= '0;
            out_last_reg  <= 1'b1;
            out_total_reg <= count_inc;
            out_len_reg   <= '0;
        end else if (cmd.emit) begin
            out_kind_reg  <= nfs_pkg::KIND_FRAME;
            out_byte_reg  <= rd_data_reg;
            out_last_reg  <= status.last_read;
            out_total_reg <= reject_count_reg;
            out_len_reg   <= line_length_reg;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_kind_reg;
    assign m_tlast  = out_last_reg;
    assign m_tdata  = {{nfs_pkg::PAD_W{1'b0}}, out_len_reg, out_total_reg, out_byte_reg};

endmodule

// ===== src/newline_frame_splitter.sv =====
// Top level of the newline frame splitter: controller and datapath.
//
//   Channel   Direction  Handshake            Contents
//   s_        in         s_tvalid/s_tready    tdata: data_byte; tuser: mode
//   m_        out        m_tvalid/m_tready    tdata: frame_byte, oversize_total,
//                                             pending_length; tuser: kind; tlast: last
//   cfg_      in         cfg_wr_en            frame_limit
//
// A data byte, clear command or oversize notice is handled in ST_IDLE; a newline that ends a
// non-empty line passes through ST_FETCH and ST_SEND, and each emitted byte is read through the single
// registered read port of the 64-byte line buffer; s_tready stays low until the last byte is sent.
// Reset is synchronous and active low; the line buffer is not cleared.
// A stalled output register holds its word and stops both the read-out and s_tready.
module newline_frame_splitter (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           cfg_wr_en,
    input  logic [nfs_pkg::LEN_W-1:0]      cfg_wr_data,   // frame_limit
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [7:0]                     s_tdata,       // [7:0] data_byte
    input  logic                           s_tuser,       // [0] mode
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [nfs_pkg::TDATA_W-1:0]    m_tdata,       // [7:0] frame_byte, [39:8]
                                                          // oversize_total, [46:40]
                                                          // pending_length
    output logic                           m_tuser,       // [0] kind
    output logic                           m_tlast
);

    nfs_pkg::ctrl_cmd_t  cmd;
    nfs_pkg::dp_status_t status;

    nfs_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    nfs_datapath u_datapath (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser),
        .m_tlast     (m_tlast),
        .cmd         (cmd),
        .status      (status)
    );

endmodule

// ===== sim/newline_frame_splitter_tb.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for the newline frame splitter, with a built-in line predictor.
module newline_frame_splitter_tb;

    localparam int DRAIN_CYCLES = 12;
    localparam int HOLD_CYCLES  = 200;
    localparam int PHASE_WORDS  = 36;
    localparam int N_PHASES     = 7;

    typedef struct packed {
        logic                        kind;
        logic [nfs_pkg::BYTE_W-1:0]  frame_byte;
        logic                        last;
        logic [nfs_pkg::COUNT_W-1:0] total;
        logic [nfs_pkg::LEN_W-1:0]   pending;
    } frame_word_t;

    typedef struct packed {
        logic                       is_cfg;
        logic                       mode;
        logic [nfs_pkg::BYTE_W-1:0] data_byte;
        logic [nfs_pkg::LEN_W-1:0]  limit;
        logic                       typed;
        frame_word_t                word;
    } stim_row_t;

    localparam frame_word_t NO_WORD = '0;
    localparam int N_DIRECTED = 27;

    localparam stim_row_t DIRECTED [N_DIRECTED] = '{
        '{1'b1, nfs_pkg::MODE_DATA,  8'h00,          7'd1,   1'b0, NO_WORD},
        '{1'b0, nfs_pkg::MODE_DATA,  8'h41,          7'd0,   1'b0, NO_WORD},
        '{1'b0, nfs_pkg::MODE_DATA,  8'h00,          7'd0,   1'b1,
          '{nfs_pkg::KIND_NOTICE, 8'h00, 1'b1, 32'd1, 7'd0}},
        '{1'b0, nfs_pkg::MODE_DATA,  8'hFF,          7'd0,   1'b0, NO_WORD},
        '{1'b0, nfs_pkg::MODE_DATA,  nfs_pkg::CH_LF, 7'd0,   1'b0, NO_WORD},
        '{1'b0, nfs_pkg::MODE_DATA,  8'hFF,          7'd0,   1'b0, NO_WORD},
        '{1'b0, nfs_pkg::MODE_DATA,  nfs_pkg::CH_LF, 7'd0,   1'b1,
          '{nfs_pkg::KIND_FRAME, 8'hFF, 1'b1, 32'd1, 7'd0}},
        '{1'b0, nfs_pkg::MODE_DATA,  nfs_pkg::CH_LF, 7'd0,   1'b0, NO_WORD},
        '{1'b1, nfs_pkg::MODE_DATA,  8'h00,          7'd0,   1'b0, NO_WORD},
        '{1'b0, nfs_pkg::MODE_DATA,  8'h80,          7'd0,   1'b0, NO_WORD},
        '{1'b0, nfs_pkg::MODE_DATA,  8'h01,          7'd0,   1'b1,
          '{nfs_pkg::KIND_NOTICE, 8'h00, 1'b1, 32'd2, 7'd0}},
        '{1'b0, nfs_pkg::MODE_CLEAR, nfs_pkg::CH_LF, 7'd0,   1'b0, NO_WORD},
        '{1'b0, nfs_pkg::MODE_DATA,  8'h7F,          7'd0,   1'b0, NO_WORD},
        '{1'b0, nfs_pkg::MODE_DATA,  nfs_pkg::CH_LF, 7'd0,   1'b1,
          '{nfs_pkg::KIND_FRAME, 8'h7F, 1'b1, 32'd0, 7'd0}},
        '{1'b1, nfs_pkg::MODE_DATA,  8'h00,          7'd2,   1'b0, NO_WORD},
        '{1'b0, nfs_pkg::MODE_DATA,  8'h61,          7'd0,   1'b0, NO_WORD},
        '{1'b0, nfs_pkg::MODE_DATA,  nfs_pkg::CH_CR, 7'd0,   1'b0, NO_WORD},
        '{1'b0, nfs_pkg::MODE_DATA,  nfs_pkg::CH_LF, 7'd0,   1'b1,
          '{nfs_pkg::KIND_FRAME, 8'h61, 1'b1, 32'd0, 7'd0}},
        '{1'b0, nfs_pkg::MODE_DATA,  8'h61,          7'd0,   1'b0, NO_WORD},
        '{1'b0, nfs_pkg::MODE_DATA,  8'h62,          7'd0,   1'b0, NO_WORD},
        '{1'b0, nfs_pkg::MODE_DATA,  nfs_pkg::CH_CR, 7'd0,   1'b1,
          '{nfs_pkg::KIND_NOTICE, 8'h00, 1'b1, 32'd1, 7'd0}},
        '{1'b0, nfs_pkg::MODE_DATA,  nfs_pkg::CH_LF, 7'd0,   1'b0, NO_WORD},
        '{1'b1, nfs_pkg::MODE_DATA,  8'h00,          7'd127, 1'b0, NO_WORD},
        '{1'b0, nfs_pkg::MODE_DATA,  8'h68,          7'd0,   1'b0, NO_WORD},
        '{1'b0, nfs_pkg::MODE_DATA,  nfs_pkg::CH_CR, 7'd0,   1'b0, NO_WORD},
        '{1'b0, nfs_pkg::MODE_DATA,  nfs_pkg::CH_CR, 7'd0,   1'b0, NO_WORD},
        '{1'b0, nfs_pkg::MODE_DATA,  nfs_pkg::CH_LF, 7'd0,   1'b0, NO_WORD}
    };

    logic                          aclk        = 1'b0;
    logic                          aresetn     = 1'b0;
    logic                          cfg_wr_en   = 1'b0;
    logic [nfs_pkg::LEN_W-1:0]     cfg_wr_data = '0;
    logic                          s_tvalid    = 1'b0;
    logic                          s_tready;
    logic [7:0]                    s_tdata     = '0;
    logic                          s_tuser     = 1'b0;
    logic                          m_tvalid;
    logic                          m_tready    = 1'b0;
    logic [nfs_pkg::TDATA_W-1:0]   m_tdata;
    logic                          m_tuser;
    logic                          m_tlast;

    logic [nfs_pkg::BYTE_W-1:0]    line_buf [nfs_pkg::MAX_FRAME];
    int unsigned                   line_len     = 0;
    logic                          skipping     = 1'b0;
    logic [nfs_pkg::COUNT_W-1:0]   reject_total = '0;
    logic [nfs_pkg::LEN_W-1:0]     limit_reg    = nfs_pkg::LIMIT_RESET;
    frame_word_t                   expected_words [$];

    logic                          failed     = 1'b0;
    logic                          idle_on    = 1'b1;
    int unsigned                   hold_left  = 0;
    int unsigned                   sent_items = 0;

    newline_frame_splitter dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser),
        .m_tlast     (m_tlast)
    );

    always #5 aclk = ~aclk;

    function automatic int unsigned frame_step(input logic mode,
                                               input logic [nfs_pkg::BYTE_W-1:0] b);
        int unsigned n;
        int unsigned i;
        int unsigned lim;
        frame_word_t w;
        if (mode == nfs_pkg::MODE_CLEAR) begin
            line_len     = 0;
            skipping     = 1'b0;
            reject_total = '0;
            return 0;
        end
        if (skipping) begin
            if (b == nfs_pkg::CH_LF) begin
                skipping = 1'b0;
            end
            return 0;
        end
        if (b == nfs_pkg::CH_LF) begin
            n = line_len;
            if (n > 0 && line_buf[nfs_pkg::ADDR_W'(n - 1)] == nfs_pkg::CH_CR) begin
                n--;
            end
            line_len = 0;
            for (i = 0; i < n; i++) begin
                w.kind       = nfs_pkg::KIND_FRAME;
                w.frame_byte = line_buf[nfs_pkg::ADDR_W'(i)];
                w.last       = (i + 1 == n);
                w.total      = reject_total;
                w.pending    = nfs_pkg::LEN_W'(line_len);
                expected_words.insert(expected_words.size(), w);
            end
            return n;
        end
        lim = (limit_reg == 0) ? 1 :
              (limit_reg > nfs_pkg::MAX_FRAME) ? nfs_pkg::MAX_FRAME : limit_reg;
        if (line_len + 1 > lim) begin
            line_len = 0;
            if (reject_total != nfs_pkg::COUNT_MAX) begin
                reject_total++;
            end
            skipping     = 1'b1;
            w.kind       = nfs_pkg::KIND_NOTICE;
            w.frame_byte = '0;
            w.last       = 1'b1;
            w.total      = reject_total;
            w.pending    = nfs_pkg::LEN_W'(line_len);
            expected_words.insert(expected_words.size(), w);
            return 1;
        end
        if (line_len < nfs_pkg::MAX_FRAME) begin
            line_buf[nfs_pkg::ADDR_W'(line_len)] = b;
            line_len++;
        end
        return 0;
    endfunction

    function automatic void check_field(input string name,
                                        input logic [nfs_pkg::COUNT_W-1:0] want,
                                        input logic [nfs_pkg::COUNT_W-1:0] got);
        if (got !== want) begin
            $error("%s mismatch: expected %0h, got %0h", name, want, got);
            failed = 1'b1;
        end
    endfunction

    task automatic send_word(input logic mode, input logic [nfs_pkg::BYTE_W-1:0] b,
                             input logic typed, input frame_word_t typed_word);
        int unsigned n;
        if (idle_on && $urandom_range(3) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(5, 1)) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= mode;
        s_tdata  <= b;
        do @(posedge aclk); while (!s_tready);
        n = frame_step(mode, b);
        if (typed) begin
            repeat (n) expected_words.delete(expected_words.size() - 1);
            expected_words.insert(expected_words.size(), typed_word);
        end
        sent_items++;
    endtask

    task automatic send_data(input logic [nfs_pkg::BYTE_W-1:0] b);
        send_word(nfs_pkg::MODE_DATA, b, 1'b0, NO_WORD);
    endtask

    task automatic send_line(input int unsigned len, input logic end_cr);
        int unsigned k;
        logic [nfs_pkg::BYTE_W-1:0] b;
        for (k = 0; k < len; k++) begin
            do b = nfs_pkg::BYTE_W'($urandom_range(255)); while (b == nfs_pkg::CH_LF);
            if (end_cr && k + 1 == len) begin
                b = nfs_pkg::CH_CR;
            end
            send_data(b);
        end
        send_data(nfs_pkg::CH_LF);
    endtask

    task automatic settle();
        s_tvalid <= 1'b0;
        while (expected_words.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic set_limit(input logic [nfs_pkg::LEN_W-1:0] v);
        settle();
        cfg_wr_data <= v;
        cfg_wr_en   <= 1'b1;
        @(posedge aclk);
        cfg_wr_en   <= 1'b0;
        limit_reg = v;
    endtask

    initial begin
        forever begin
            if (hold_left != 0) begin
                m_tready <= 1'b0;
                repeat (hold_left) @(posedge aclk);
                hold_left = 0;
            end else if (idle_on && $urandom_range(4) == 0) begin
                m_tready <= 1'b0;
                repeat ($urandom_range(5, 1)) @(posedge aclk);
            end
            m_tready <= 1'b1;
            @(posedge aclk);
        end
    end

    always @(posedge aclk) begin
        frame_word_t e;
        if (aresetn && m_tvalid && m_tready) begin
            if (expected_words.size() == 0) begin
                $error("unexpected word: kind %0d, frame_byte %02h", m_tuser, m_tdata[7:0]);
                failed = 1'b1;
            end else begin
                e = expected_words.pop_front();
                check_field("kind", nfs_pkg::COUNT_W'(e.kind), nfs_pkg::COUNT_W'(m_tuser));
                check_field("frame_byte", nfs_pkg::COUNT_W'(e.frame_byte),
                            nfs_pkg::COUNT_W'(m_tdata[nfs_pkg::BYTE_W-1:0]));
                check_field("last", nfs_pkg::COUNT_W'(e.last), nfs_pkg::COUNT_W'(m_tlast));
                check_field("oversize_total", e.total,
                            m_tdata[nfs_pkg::BYTE_W+nfs_pkg::COUNT_W-1:nfs_pkg::BYTE_W]);
                check_field("pending_length", nfs_pkg::COUNT_W'(e.pending),
                            nfs_pkg::COUNT_W'(m_tdata[nfs_pkg::FIELD_W-1:
                                                      nfs_pkg::BYTE_W+nfs_pkg::COUNT_W]));
            end
        end
    end

    initial begin
        #5_000_000;
        $display("FAIL newline_frame_splitter");
        $finish;
    end

    initial begin
        int unsigned r;
        int unsigned p;
        int unsigned phase_end;
        int unsigned eff;
        int unsigned len;
        int unsigned pick;
        logic [nfs_pkg::LEN_W-1:0] lim;
        logic [nfs_pkg::BYTE_W-1:0] b;

        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        for (r = 0; r < N_DIRECTED; r++) begin
            if (DIRECTED[r].is_cfg) begin
                set_limit(DIRECTED[r].limit);
            end else begin
                send_word(DIRECTED[r].mode, DIRECTED[r].data_byte, DIRECTED[r].typed,
                          DIRECTED[r].word);
            end
        end

        for (p = 0; p < N_PHASES; p++) begin
            case (p)
                0, 6: begin
                    lim = nfs_pkg::LIMIT_RESET;
                end
                1: begin
                    lim = nfs_pkg::LEN_W'(1);
                end
                2: begin
                    lim = nfs_pkg::LEN_W'($urandom_range(10, 2));
                end
                3: begin
                    lim = '1;
                end
                4: begin
                    lim = '0;
                end
                default: begin
                    lim = nfs_pkg::LEN_W'($urandom_range(63, 11));
                end
            endcase
            set_limit(lim);
            idle_on = (p != 2 && p != N_PHASES - 1);
            if (p == 0) begin
                hold_left = HOLD_CYCLES;
            end
            eff = (lim == 0) ? 1 : (lim > nfs_pkg::MAX_FRAME) ? nfs_pkg::MAX_FRAME : lim;
            phase_end = sent_items + PHASE_WORDS;
            while (sent_items < phase_end) begin
                pick = $urandom_range(99);
                if (pick < 75) begin
                    if ($urandom_range(9) == 0) begin
                        len = eff + $urandom_range(3);
                    end else begin
                        len = $urandom_range((eff < 12) ? eff : 12);
                    end
                    send_line(len, $urandom_range(2) == 0);
                end else if (pick < 85) begin
                    send_word(nfs_pkg::MODE_CLEAR, nfs_pkg::BYTE_W'($urandom), 1'b0, NO_WORD);
                end else begin
                    b = ($urandom_range(3) == 0) ? nfs_pkg::CH_LF
                                                 : nfs_pkg::BYTE_W'($urandom_range(255));
                    send_data(b);
                end
            end
        end

        settle();
        if (!failed) begin
            $display("PASS newline_frame_splitter");
        end else begin
            $display("FAIL newline_frame_splitter");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
src/nfs_pkg.sv
src/nfs_ctrl.sv
src/nfs_datapath.sv
src/newline_frame_splitter.sv
sim/newline_frame_splitter_tb.sv
